FILE: rtl/rope_pkg.sv
// Shared constants, command and result types for the rotary position embedding unit.
`default_nettype none

package rope_pkg;

    // Sizing of the head vector, position range and trig table
    localparam int MAX_HEAD_DIM  = 128;
    localparam int MAX_POSITIONS = 2048;
    localparam int TABLE_DEPTH   = 131072;
    localparam int TABLE_AW      = 17;
    localparam int PEND_DEPTH    = MAX_HEAD_DIM / 2;
    localparam int PEND_AW       = (MAX_HEAD_DIM > 2) ? $clog2(PEND_DEPTH) : 1;
    localparam int CNT_W         = $clog2(MAX_HEAD_DIM + 1);
    localparam int HALF_W        = $clog2(MAX_HEAD_DIM / 2 + 1);
    localparam int POS_W         = 11;
    localparam int VAL_W         = 16;
    localparam int IDX_W         = 7;
    localparam int ADDR_SUM_W    = POS_W + HALF_W + 1;

    // Queue depths between the parts and at the result side
    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = 2;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = 2;

    // Fixed-point constants
    localparam logic signed [VAL_W-1:0] ONE_Q14 = 16'sd16384;

    // Configuration register indexes and reset values
    localparam logic [1:0] CFG_HEAD_DIM    = 2'd0;
    localparam logic [1:0] CFG_INTERLEAVED = 2'd1;
    localparam logic [1:0] CFG_ROTATE      = 2'd2;
    localparam logic [7:0] HEAD_DIM_RST    = 8'd128;

    // Operation handed from the front part to the back part
    typedef enum logic [1:0] {
        OP_TABLE,
        OP_STASH,
        OP_ROTATE
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic [TABLE_AW-1:0]      tab_addr;
        logic [2*VAL_W-1:0]       tab_data;
        logic signed [VAL_W-1:0]  value;
        logic [PEND_AW-1:0]       pend_addr;
        logic [IDX_W-1:0]         first_idx;
        logic [IDX_W-1:0]         second_idx;
        logic                     done;
        logic                     rotate;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]         element_index;
        logic signed [VAL_W-1:0]  rotated_value;
        logic                     last_of_run;
        logic                     head_done;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/rope_front.sv
// Front part: configuration registers, element counter and item classification.
`default_nettype none

module rope_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [7:0]                      cfg_data,
    input  wire logic                            push,
    input  wire logic                            kind,
    input  wire logic [rope_pkg::TABLE_AW-1:0]   table_index,
    input  wire logic signed [15:0]              table_cos,
    input  wire logic signed [15:0]              table_sin,
    input  wire logic signed [15:0]              value,
    input  wire logic [rope_pkg::POS_W-1:0]      position,
    input  wire logic                            cmd_full,
    output logic                                 cmd_push,
    output rope_pkg::cmd_t                       cmd
);

    localparam logic [rope_pkg::CNT_W-1:0] MAX_DIM_EVEN =
        rope_pkg::CNT_W'(rope_pkg::MAX_HEAD_DIM & ~1);
    localparam logic [rope_pkg::CNT_W-1:0] MIN_DIM = rope_pkg::CNT_W'(2);

    logic [7:0]                          head_dim_reg, head_dim_next;
    logic                                interleaved_reg, interleaved_next;
    logic                                rotate_reg, rotate_next;
    logic [rope_pkg::CNT_W-1:0]          count_reg, count_next;

    logic [rope_pkg::CNT_W-1:0]          dim;
    logic [rope_pkg::HALF_W-1:0]         half;
    logic [rope_pkg::CNT_W-1:0]          idx;
    logic [rope_pkg::CNT_W-1:0]          idx_inc;
    logic                                stash;
    logic [rope_pkg::PEND_AW-1:0]        pair;
    logic [rope_pkg::CNT_W-1:0]          first_full;
    logic                                done;
    logic [rope_pkg::POS_W-1:0]          pos_sat;
    logic [rope_pkg::ADDR_SUM_W-1:0]     addr_full;

    // Effective head size: drop the low bit, clamp to the legal range
    always_comb
    begin
        dim = rope_pkg::CNT_W'({head_dim_reg[7:1], 1'b0});
        if (dim < MIN_DIM)
        begin
            dim = MIN_DIM;
        end
        if (dim > MAX_DIM_EVEN)
        begin
            dim = MAX_DIM_EVEN;
        end
        half = rope_pkg::HALF_W'(dim >> 1);
    end

    // Classify a data element: first of a pair is stashed, second rotates both
    always_comb
    begin
        idx     = (count_reg >= dim) ? '0 : count_reg;
        idx_inc = idx + rope_pkg::CNT_W'(1);
        done    = (idx_inc >= dim);
        if (interleaved_reg)
        begin
            stash      = ~idx[0];
            pair       = rope_pkg::PEND_AW'(idx >> 1);
            first_full = idx - rope_pkg::CNT_W'(1);
        end
        else
        begin
            stash      = (idx < rope_pkg::CNT_W'(half));
            pair       = rope_pkg::PEND_AW'(idx - rope_pkg::CNT_W'(half));
            first_full = rope_pkg::CNT_W'(pair);
        end
    end

    // Table row address from the saturated position
    always_comb
    begin
        if (int'(position) >= rope_pkg::MAX_POSITIONS)
        begin
            pos_sat = rope_pkg::POS_W'(rope_pkg::MAX_POSITIONS - 1);
        end
        else
        begin
            pos_sat = position;
        end
        addr_full = rope_pkg::ADDR_SUM_W'(pos_sat) * rope_pkg::ADDR_SUM_W'(half)
                  + rope_pkg::ADDR_SUM_W'(pair);
    end

    // Build the transaction for the command queue
    always_comb
    begin
        cmd_push       = push & ~cmd_full;
        cmd.tab_data   = {table_cos, table_sin};
        cmd.value      = value;
        cmd.first_idx  = rope_pkg::IDX_W'(first_full);
        cmd.second_idx = rope_pkg::IDX_W'(idx);
        cmd.done       = done;
        cmd.rotate     = rotate_reg;
        if (!kind)
        begin
            cmd.op        = rope_pkg::OP_TABLE;
            cmd.tab_addr  = table_index;
            cmd.pend_addr = '0;
        end
        else if (stash)
        begin
            cmd.op        = rope_pkg::OP_STASH;
            cmd.tab_addr  = '0;
            cmd.pend_addr = interleaved_reg ? '0 : rope_pkg::PEND_AW'(idx);
        end
        else
        begin
            cmd.op        = rope_pkg::OP_ROTATE;
            cmd.tab_addr  = rope_pkg::TABLE_AW'(addr_full);
            cmd.pend_addr = interleaved_reg ? '0 : pair;
        end
    end

    // Next state of configuration and element counter
    always_comb
    begin
        head_dim_next    = head_dim_reg;
        interleaved_next = interleaved_reg;
        rotate_next      = rotate_reg;
        count_next       = count_reg;
        if (cmd_push && kind)
        begin
            count_next = (stash || !done) ? idx_inc : '0;
        end
        if (cfg_write)
        begin
            case (cfg_index)
                rope_pkg::CFG_HEAD_DIM:
                begin
                    head_dim_next = cfg_data;
                    count_next    = '0;
                end
                rope_pkg::CFG_INTERLEAVED:
                begin
                    interleaved_next = cfg_data[0];
                    count_next       = '0;
                end
                rope_pkg::CFG_ROTATE:
                begin
                    rotate_next = cfg_data[0];
                end
                default:
                begin
                    count_next = count_next;
                end
            endcase
        end
    end

    // Hold configuration and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_dim_reg    <= rope_pkg::HEAD_DIM_RST;
            interleaved_reg <= 1'b0;
            rotate_reg      <= 1'b1;
            count_reg       <= '0;
        end
        else
        begin
            head_dim_reg    <= head_dim_next;
            interleaved_reg <= interleaved_next;
            rotate_reg      <= rotate_next;
            count_reg       <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rope_cmd_fifo.sv
// Short command queue between the front part and the back part.
`default_nettype none

module rope_cmd_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire rope_pkg::cmd_t din,
    input  wire logic           pop,
    output logic                full,
    output logic                empty,
    output rope_pkg::cmd_t      dout
);

    rope_pkg::cmd_t                  entry_reg [rope_pkg::CMD_DEPTH];
    logic [rope_pkg::CMD_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [rope_pkg::CMD_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [rope_pkg::CMD_AW:0]       count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    // Status and head of queue
    always_comb
    begin
        full    = (count_reg == (rope_pkg::CMD_AW+1)'(rope_pkg::CMD_DEPTH));
        empty   = (count_reg == '0);
        dout    = entry_reg[rd_ptr_reg];
        do_push = push & ~full;
        do_pop  = pop & ~empty;
        wr_ptr_next = do_push ? wr_ptr_reg + rope_pkg::CMD_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + rope_pkg::CMD_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (rope_pkg::CMD_AW+1)'(do_push)
                    - (rope_pkg::CMD_AW+1)'(do_pop);
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rope_back.sv
// Back part: trig table, pending-element buffer, rotation datapath and result queue.
`default_nettype none

module rope_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cmd_empty,
    input  wire rope_pkg::cmd_t                    cmd,
    output logic                                   cmd_pop,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [rope_pkg::IDX_W-1:0]             element_index,
    output logic signed [rope_pkg::VAL_W-1:0]      rotated_value,
    output logic                                   last_of_run,
    output logic                                   head_done
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_RES0,
        ST_RES1
    } state_t;

    state_t                                    state_reg, state_next;
    logic [rope_pkg::IDX_W-1:0]                first_idx_reg, first_idx_next;
    logic [rope_pkg::IDX_W-1:0]                second_idx_reg, second_idx_next;
    logic                                      done_reg, done_next;
    logic                                      rotate_reg, rotate_next;

    logic [2*rope_pkg::VAL_W-1:0]              trig_mem [rope_pkg::TABLE_DEPTH];
    logic signed [rope_pkg::VAL_W-1:0]         pend_mem [rope_pkg::PEND_DEPTH];
    logic [2*rope_pkg::VAL_W-1:0]              trig_rd_reg;
    logic signed [rope_pkg::VAL_W-1:0]         pend_rd_reg;
    logic signed [rope_pkg::VAL_W-1:0]         a1_reg;

    logic signed [rope_pkg::VAL_W-1:0]         c_sel;
    logic signed [rope_pkg::VAL_W-1:0]         s_sel;
    logic signed [2*rope_pkg::VAL_W-1:0]       m_a0c, m_a1s, m_a1c, m_a0s;
    logic signed [2*rope_pkg::VAL_W-1:0]       p_a0c_reg, p_a1s_reg, p_a1c_reg, p_a0s_reg;
    logic signed [2*rope_pkg::VAL_W:0]         acc;

    rope_pkg::result_t                         out_q [rope_pkg::OUT_DEPTH];
    rope_pkg::result_t                         res;
    logic [rope_pkg::OUT_AW-1:0]               owr_ptr_reg, owr_ptr_next;
    logic [rope_pkg::OUT_AW-1:0]               ord_ptr_reg, ord_ptr_next;
    logic [rope_pkg::OUT_AW:0]                 ocount_reg, ocount_next;
    logic                                      res_push;
    logic                                      res_pop;
    logic                                      room2;
    logic                                      issue_rd;

    // Round half up from Q10.22 to Q7.8, then saturate to 16 bits
    function automatic logic signed [rope_pkg::VAL_W-1:0] round_sat(
        input logic signed [2*rope_pkg::VAL_W:0] a
    );
        logic signed [2*rope_pkg::VAL_W+1:0] biased;
        logic signed [2*rope_pkg::VAL_W-12:0] shifted;
        biased  = (2*rope_pkg::VAL_W+2)'(a) + 34'sd8192;
        shifted = (2*rope_pkg::VAL_W-11)'(biased >>> 14);
        if (shifted > 21'sd32767)
        begin
            round_sat = 16'sh7FFF;
        end
        else if (shifted < -21'sd32768)
        begin
            round_sat = 16'sh8000;
        end
        else
        begin
            round_sat = shifted[rope_pkg::VAL_W-1:0];
        end
    endfunction

    // Dispatch: rotation waits for room for both results
    always_comb
    begin
        room2    = (ocount_reg <= (rope_pkg::OUT_AW+1)'(rope_pkg::OUT_DEPTH - 2));
        cmd_pop  = (state_reg == ST_IDLE) && !cmd_empty
                 && ((cmd.op != rope_pkg::OP_ROTATE) || room2);
        issue_rd = cmd_pop && (cmd.op == rope_pkg::OP_ROTATE);
    end

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        first_idx_next  = first_idx_reg;
        second_idx_next = second_idx_reg;
        done_next       = done_reg;
        rotate_next     = rotate_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (issue_rd)
                begin
                    state_next      = ST_MULT;
                    first_idx_next  = cmd.first_idx;
                    second_idx_next = cmd.second_idx;
                    done_next       = cmd.done;
                    rotate_next     = cmd.rotate;
                end
            end
            ST_MULT:
            begin
                state_next = ST_RES0;
            end
            ST_RES0:
            begin
                state_next = ST_RES1;
            end
            ST_RES1:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold sequencer state and the pair's tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_idx_reg  <= '0;
            second_idx_reg <= '0;
            done_reg       <= 1'b0;
            rotate_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_idx_reg  <= first_idx_next;
            second_idx_reg <= second_idx_next;
            done_reg       <= done_next;
            rotate_reg     <= rotate_next;
        end
    end

    // Trig table: write on table transactions, registered read on rotation
    always_ff @(posedge clk)
    begin
        if (cmd_pop && (cmd.op == rope_pkg::OP_TABLE))
        begin
            trig_mem[cmd.tab_addr] <= cmd.tab_data;
        end
        if (issue_rd)
        begin
            trig_rd_reg <= trig_mem[cmd.tab_addr];
        end
    end

    // Pending first elements: write on stash, registered read on rotation
    always_ff @(posedge clk)
    begin
        if (cmd_pop && (cmd.op == rope_pkg::OP_STASH))
        begin
            pend_mem[cmd.pend_addr] <= cmd.value;
        end
        if (issue_rd)
        begin
            pend_rd_reg <= pend_mem[cmd.pend_addr];
            a1_reg      <= cmd.value;
        end
    end

    // Select cos/sin and form the four products
    always_comb
    begin
        c_sel = rotate_reg ? trig_rd_reg[2*rope_pkg::VAL_W-1:rope_pkg::VAL_W]
                           : rope_pkg::ONE_Q14;
        s_sel = rotate_reg ? trig_rd_reg[rope_pkg::VAL_W-1:0] : '0;
        m_a0c = pend_rd_reg * c_sel;
        m_a1s = a1_reg * s_sel;
        m_a1c = a1_reg * c_sel;
        m_a0s = pend_rd_reg * s_sel;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MULT)
        begin
            p_a0c_reg <= m_a0c;
            p_a1s_reg <= m_a1s;
            p_a1c_reg <= m_a1c;
            p_a0s_reg <= m_a0s;
        end
    end

    // Sum, round and tag one result per cycle
    always_comb
    begin
        if (state_reg == ST_RES0)
        begin
            acc = (2*rope_pkg::VAL_W+1)'(p_a0c_reg) - (2*rope_pkg::VAL_W+1)'(p_a1s_reg);
        end
        else
        begin
            acc = (2*rope_pkg::VAL_W+1)'(p_a1c_reg) + (2*rope_pkg::VAL_W+1)'(p_a0s_reg);
        end
        res.element_index = (state_reg == ST_RES0) ? first_idx_reg : second_idx_reg;
        res.rotated_value = round_sat(acc);
        res.last_of_run   = (state_reg == ST_RES1);
        res.head_done     = done_reg;
        res_push          = (state_reg == ST_RES0) || (state_reg == ST_RES1);
    end

    // Result queue control
    always_comb
    begin
        empty        = (ocount_reg == '0);
        res_pop      = pop & ~empty;
        owr_ptr_next = res_push ? owr_ptr_reg + rope_pkg::OUT_AW'(1) : owr_ptr_reg;
        ord_ptr_next = res_pop ? ord_ptr_reg + rope_pkg::OUT_AW'(1) : ord_ptr_reg;
        ocount_next  = ocount_reg + (rope_pkg::OUT_AW+1)'(res_push)
                     - (rope_pkg::OUT_AW+1)'(res_pop);
        element_index = out_q[ord_ptr_reg].element_index;
        rotated_value = out_q[ord_ptr_reg].rotated_value;
        last_of_run   = out_q[ord_ptr_reg].last_of_run;
        head_done     = out_q[ord_ptr_reg].head_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_ptr_reg <= '0;
            ord_ptr_reg <= '0;
            ocount_reg  <= '0;
        end
        else
        begin
            owr_ptr_reg <= owr_ptr_next;
            ord_ptr_reg <= ord_ptr_next;
            ocount_reg  <= ocount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            out_q[owr_ptr_reg] <= res;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rotary_position_embedding_unit.sv
// A rotating element's first result passes the command queue, the table and pending-buffer
//   read registers, the product registers and the result queue; the second follows next cycle.
// The back end takes a table write or a first-of-pair element in its idle state and steps a
//   second-of-pair element through table read, multiply and two result writes before the next.
// A 4-entry command queue lets the input run ahead; a 4-entry result queue absorbs pop stalls.
// Reset clears queues, element counter and configuration (head_dim 128, split, rotate on);
//   the trig table and pending-element buffer are not cleared and hold garbage until written.
`default_nettype none

module rotary_position_embedding_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [7:0]           cfg_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic                 kind,
    input  wire logic [16:0]          table_index,
    input  wire logic signed [15:0]   table_cos,
    input  wire logic signed [15:0]   table_sin,
    input  wire logic signed [15:0]   value,
    input  wire logic [10:0]          position,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [6:0]                element_index,
    output logic signed [15:0]        rotated_value,
    output logic                      last_of_run,
    output logic                      head_done
);

    logic               cmd_push;
    logic               cmd_full;
    logic               cmd_empty;
    logic               cmd_pop;
    rope_pkg::cmd_t     cmd_in;
    rope_pkg::cmd_t     cmd_out;

    assign full = cmd_full;

    rope_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .kind        (kind),
        .table_index (table_index),
        .table_cos   (table_cos),
        .table_sin   (table_sin),
        .value       (value),
        .position    (position),
        .cmd_full    (cmd_full),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in)
    );

    rope_cmd_fifo u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .pop   (cmd_pop),
        .full  (cmd_full),
        .empty (cmd_empty),
        .dout  (cmd_out)
    );

    rope_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_empty     (cmd_empty),
        .cmd           (cmd_out),
        .cmd_pop       (cmd_pop),
        .empty         (empty),
        .pop           (pop),
        .element_index (element_index),
        .rotated_value (rotated_value),
        .last_of_run   (last_of_run),
        .head_done     (head_done)
    );

endmodule

`default_nettype wire

FILE: rtl/rope_checker.sv
// Port-level checks on the result stream of the rotary position embedding unit.
`default_nettype none

module rope_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          full,
    input  wire logic          empty,
    input  wire logic          pop,
    input  wire logic [6:0]    element_index,
    input  wire logic [15:0]   rotated_value,
    input  wire logic          last_of_run,
    input  wire logic          head_done
);

    // While reset is held low, the result queue is empty and the command queue is not full
    a_reset_idle: assert property (@(posedge clk)
        (!rst_n ##1 !rst_n) |-> (empty && !full))
        else $error("queues not empty during reset");

    // A waiting result holds until popped
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(rotated_value) && $stable(element_index)
                              && $stable(last_of_run) && $stable(head_done)))
        else $error("waiting result changed");

    // The first result of a pair is followed at once by its partner
    a_pair_second: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_of_run) |=> (!empty && last_of_run
                                             && (head_done == $past(head_done))
                                             && (element_index > $past(element_index))))
        else $error("second result of pair missing or inconsistent");

    // After a pair's second result comes nothing or a new pair
    a_pair_first: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && last_of_run) |=> (empty || !last_of_run))
        else $error("pair boundary broken");

endmodule

bind rotary_position_embedding_unit rope_checker u_rope_checker (.*);

`default_nettype wire
